// File: sv/cdq_pkg.sv
// Package for the circular deque: sizes, request and status codes, and the
// command/status structs between the controller and the datapath.
// No dependencies.
package cdq_pkg;

    // Ring store geometry
    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 4;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_CAPACITY = 1'b0;   // selected by paddr[2]

    // Request codes
    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_REAR   = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic exec;       // execute the request on the input ports
        logic load_pop;   // capture the ring read data as the popped word
    } cdq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_hit;    // current request is a pop that will read the ring
    } cdq_stat_t;

endpackage

// File: sv/cdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/cdq_ctrl.sv
// Controller for the circular deque: sequences accept, ring read and result beat.
// Depends on cdq_pkg.
module cdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  cdq_pkg::cdq_stat_t stat,
    output cdq_pkg::cdq_cmd_t  cmd
);
    import cdq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_SEND = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.exec     = 1'b0;
        cmd.load_pop = 1'b0;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = stat.pop_hit ? S_LOAD : S_SEND;
                end
            end
            S_LOAD:
            begin
                cmd.load_pop = 1'b1;
                state_next   = S_SEND;
            end
            S_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/cdq_dpath.sv
// Datapath for the circular deque: indices, empty flag, capacity register,
// ring RAM and result registers.
// Depends on cdq_pkg and cdq_ram.
module cdq_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cdq_pkg::cdq_cmd_t           cmd,
    output cdq_pkg::cdq_stat_t          stat,
    input  logic [1:0]                  req_type,
    input  logic signed [31:0]          push_value,
    output logic signed [31:0]          pop_value,
    output logic [1:0]                  status,
    input  logic                        cfg_write,
    input  logic [cdq_pkg::PADDR_W-1:0] cfg_addr,
    input  logic [cdq_pkg::PDATA_W-1:0] cfg_wdata,
    output logic [cdq_pkg::PDATA_W-1:0] cfg_rdata
);
    import cdq_pkg::*;

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic              empty_reg, empty_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [DATA_W-1:0] pop_value_reg;
    logic [1:0]        status_reg, status_next;

    logic [IDX_W-1:0]  cap_m1;
    logic [IDX_W-1:0]  tail_up, tail_down, head_up, head_down;
    logic              is_full, is_push;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // Effective capacity minus one: zero reads as one, above depth reads as depth
    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            cap_m1 = '0;
        end
        else if (capacity_reg > CAP_W'(DEPTH))
        begin
            cap_m1 = IDX_W'(DEPTH - 1);
        end
        else
        begin
            cap_m1 = IDX_W'(capacity_reg - CAP_W'(1));
        end
    end

    // Wrapping index steps
    assign head_up   = (head_reg >= cap_m1) ? '0 : head_reg + IDX_W'(1);
    assign tail_up   = (tail_reg >= cap_m1) ? '0 : tail_reg + IDX_W'(1);
    assign head_down = (head_reg == '0) ? cap_m1 : head_reg - IDX_W'(1);
    assign tail_down = (tail_reg == '0) ? cap_m1 : tail_reg - IDX_W'(1);

    assign is_push      = (req_type == REQ_PUSH_FRONT) || (req_type == REQ_PUSH_REAR);
    assign is_full      = !empty_reg && (tail_up == head_reg);
    assign stat.pop_hit = !is_push && !empty_reg;

    // Decide the request outcome
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = ST_DONE;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_re      = 1'b0;
        ram_raddr   = head_reg;
        if (cmd.exec)
        begin
            unique case (req_type)
                REQ_PUSH_FRONT, REQ_PUSH_REAR:
                begin
                    priority if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        ram_we     = 1'b1;
                    end
                    else if (is_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (req_type == REQ_PUSH_FRONT)
                    begin
                        head_next = head_down;
                        ram_we    = 1'b1;
                        ram_waddr = head_down;
                    end
                    else
                    begin
                        tail_next = tail_up;
                        ram_we    = 1'b1;
                        ram_waddr = tail_up;
                    end
                end
                REQ_POP_FRONT, REQ_POP_REAR:
                begin
                    if (empty_reg)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = (req_type == REQ_POP_FRONT) ? head_reg : tail_reg;
                        if (head_reg == tail_reg)
                        begin
                            empty_next = 1'b1;
                        end
                        else if (req_type == REQ_POP_FRONT)
                        begin
                            head_next = head_up;
                        end
                        else
                        begin
                            tail_next = tail_down;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    // Hold the deque control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            if (cfg_write && (cfg_addr[2] == REG_CAPACITY))
            begin
                capacity_reg <= cfg_wdata[CAP_W-1:0];
            end
        end
    end

    // Capture the result beat
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            pop_value_reg <= '1;
            status_reg    <= status_next;
        end
        else if (cmd.load_pop)
        begin
            pop_value_reg <= ram_rdata;
        end
    end

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign cfg_rdata = (cfg_addr[2] == REG_CAPACITY) ? PDATA_W'(capacity_reg) : '0;

endmodule

// File: sv/circular_deque.sv
// Double-ended queue of signed 32-bit words in an 8-entry ring RAM. Each request
// (push front, push rear, pop front, pop rear) yields one result beat with the
// popped word (-1 on pushes and refused pops) and a status: done, full or empty.
// A push or a refused pop presents its result beat in the cycle right after the
// accept; a successful pop first passes through a load state that captures the
// registered read of the ring RAM. One request is in flight at a time and the next
// is accepted the cycle after the result beat is taken. The capacity register (byte
// address 0, reset 8) sets the ring size from 1 to 8; zero acts as 1 and values
// above 8 act as 8.
// Depends on cdq_pkg, cdq_ctrl and cdq_dpath.
module circular_deque (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  req_type,
    input  logic signed [31:0]          push_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [31:0]          pop_value,
    output logic [1:0]                  status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cdq_pkg::PADDR_W-1:0] paddr,
    input  logic [cdq_pkg::PDATA_W-1:0] pwdata,
    output logic [cdq_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cdq_pkg::*;

    cdq_cmd_t  cmd;
    cdq_stat_t stat;
    logic      cfg_write;

    // Register write on the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cdq_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .push_value (push_value),
        .pop_value  (pop_value),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_addr   (paddr),
        .cfg_wdata  (pwdata),
        .cfg_rdata  (prdata)
    );

endmodule
